/* rtl/swd_pkg.sv */
// Shared types and constants for the sync-word bit deframer.
// No dependencies; imported by every rtl module of the block.
package swd_pkg;

    localparam int BYTE_W    = 8;
    localparam int NUM_LANES = 8;
    localparam int LEN_W     = 7;
    localparam int LIMIT_W   = 7;
    localparam int FRAME_W   = 16;
    localparam int CFG_W     = 64;
    localparam int ADDR_W    = 2;
    localparam int GROUP_W   = 8;
    localparam int GCNT_W    = 4;

    typedef enum logic [ADDR_W-1:0] {
        CFG_SYNC_WORD      = 2'd0,
        CFG_SYNC_LENGTH    = 2'd1,
        CFG_MISMATCH_LIMIT = 2'd2,
        CFG_FRAME_BYTES    = 2'd3
    } cfg_reg_t;

    // load enables of the three lane pipeline stages
    typedef struct packed {
        logic diff;
        logic part;
        logic match;
    } lane_en_t;

endpackage

/* rtl/swd_lane.sv */
// One correlator lane: masked mismatch count of one bit position's window.
// Depends on swd_pkg; three registered stages (xor, group counts, sum/compare).
module swd_lane #(
    parameter int SYNC_WIDTH = 64
) (
    input  logic                     clk,
    input  swd_pkg::lane_en_t        en,
    input  logic [SYNC_WIDTH-1:0]    win,
    input  logic [SYNC_WIDTH-1:0]    word,
    input  logic [SYNC_WIDTH-1:0]    mask,
    input  logic [swd_pkg::LIMIT_W-1:0] limit,
    output logic                     match
);
    import swd_pkg::*;

    localparam int NG = (SYNC_WIDTH + GROUP_W - 1) / GROUP_W;

    logic [SYNC_WIDTH-1:0]  diff_reg;
    logic [NG*GROUP_W-1:0]  pad;
    logic [GCNT_W-1:0]      part_next [NG];
    logic [GCNT_W-1:0]      part_reg  [NG];
    logic [LIMIT_W-1:0]     sum;
    logic                   match_reg;

    always_comb
    begin
        pad = '0;
        pad[SYNC_WIDTH-1:0] = diff_reg;
        for (int g = 0; g < NG; g++)
        begin
            part_next[g] = '0;
            for (int b = 0; b < GROUP_W; b++)
            begin
                part_next[g] = part_next[g] + GCNT_W'(pad[g*GROUP_W+b]);
            end
        end
        sum = '0;
        for (int g = 0; g < NG; g++)
        begin
            sum = sum + LIMIT_W'(part_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.diff)
        begin
            diff_reg <= (win ^ word) & mask;
        end
        if (en.part)
        begin
            part_reg <= part_next;
        end
        if (en.match)
        begin
            match_reg <= (sum <= limit);
        end
    end

    assign match = match_reg;

endmodule

/* rtl/swd_merge.sv */
// Merging stage: walks the eight lane results in bit order, packs frame bits,
// counts bytes and holds the output register. Depends on swd_pkg.
module swd_merge (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [swd_pkg::NUM_LANES-1:0] lane_match,
    input  logic [swd_pkg::BYTE_W-1:0]   bits,
    input  logic [swd_pkg::FRAME_W-1:0]  frame_bytes,
    output logic                         go,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [swd_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] out_byte
    output logic                         m_tlast
);
    import swd_pkg::*;

    logic               cap_reg,  cap_next;
    logic [2:0]         bip_reg,  bip_next;
    logic [BYTE_W-1:0]  pack_reg, pack_next;
    logic [FRAME_W-1:0] done_reg, done_next;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_last_reg;

    logic [FRAME_W:0]   done_inc;
    logic               last_pre;
    logic               emit;
    logic [BYTE_W-1:0]  emit_byte;
    logic               out_free;
    logic [3:0]         cnt;

    assign done_inc = {1'b0, done_reg} + (FRAME_W+1)'(1);
    assign last_pre = done_inc >= {1'b0, frame_bytes};

    always_comb
    begin
        cap_next  = cap_reg;
        pack_next = pack_reg;
        done_next = done_reg;
        cnt       = {1'b0, bip_reg};
        emit      = 1'b0;
        emit_byte = '0;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            if (cap_next)
            begin
                pack_next = {pack_next[BYTE_W-2:0], bits[BYTE_W-1-j]};
                cnt = cnt + 4'd1;
                if (cnt == 4'(BYTE_W))
                begin
                    emit      = 1'b1;
                    emit_byte = pack_next;
                    pack_next = '0;
                    cnt       = '0;
                    if (last_pre)
                    begin
                        cap_next  = 1'b0;
                        done_next = '0;
                    end
                    else
                    begin
                        done_next = done_inc[FRAME_W-1:0];
                    end
                end
            end
            else if (lane_match[j])
            begin
                cap_next  = 1'b1;
                pack_next = '0;
                cnt       = '0;
                done_next = '0;
            end
        end
        bip_next = cnt[2:0];
    end

    assign out_free = !out_valid_reg || m_tready;
    assign go       = in_valid && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= 1'b0;
            bip_reg       <= '0;
            pack_reg      <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                cap_reg  <= cap_next;
                bip_reg  <= bip_next;
                pack_reg <= pack_next;
                done_reg <= done_next;
            end
            if (go && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= last_pre;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        go && emit |=> m_tvalid)
        else $error("emitted byte not presented");
    a_hunt_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !cap_reg |-> (bip_reg == 3'd0))
        else $error("bits packed while hunting");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        go && emit && last_pre |=> (done_reg == '0))
        else $error("byte count not cleared after last byte");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(cap_reg) && $stable(bip_reg) && $stable(done_reg))
        else $error("frame state moved without a beat");
`endif

endmodule

/* rtl/sync_word_bit_deframer.sv */
// Sync-word bit deframer: hunts a sync word bit by bit with a Hamming
// threshold and emits the following frame as bytes. Uses swd_pkg, swd_lane, swd_merge.
//
// One input beat carries eight bits, earliest in the MSB, and the block takes
// a beat every cycle while the output is not stalled. Eight correlator lanes,
// one per bit position, score the sync window of each bit in parallel over
// three register stages; the merge stage then walks the eight results in
// order and packs finished bytes into the output register. The frame state
// is carried from beat to beat by the merge stage alone, which holds the pace
// at one beat per clock when the output does not stall. Output backpressure
// is absorbed by the pipeline stages before the input stalls. The user must
// write configuration only while the block is empty; the block does not enforce it.
module sync_word_bit_deframer #(
    parameter int SYNC_WIDTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [swd_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [swd_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [swd_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [swd_pkg::BYTE_W-1:0]  m_tdata,   // [7:0] out_byte
    output logic                        m_tlast
);
    import swd_pkg::*;

    logic [SYNC_WIDTH-1:0] sync_word_reg;
    logic [LEN_W-1:0]      sync_length_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [FRAME_W-1:0]    frame_bytes_reg;

    logic [SYNC_WIDTH-1:0]        shift_reg;
    logic [SYNC_WIDTH-1:0]        mask;
    logic [SYNC_WIDTH+BYTE_W-1:0] wide;
    logic [SYNC_WIDTH-1:0]        win [NUM_LANES];

    logic v1_reg, v2_reg, v3_reg;
    logic [BYTE_W-1:0] byte1_reg, byte2_reg, byte3_reg;
    logic r1, r2, r3, acc, merge_go;
    lane_en_t en;
    logic [NUM_LANES-1:0] lane_match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg   <= '0;
            sync_length_reg <= LEN_W'(32);
            limit_reg       <= '0;
            frame_bytes_reg <= FRAME_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                CFG_SYNC_WORD:      sync_word_reg   <= cfg_data[SYNC_WIDTH-1:0];
                CFG_SYNC_LENGTH:    sync_length_reg <= cfg_data[LEN_W-1:0];
                CFG_MISMATCH_LIMIT: limit_reg       <= cfg_data[LIMIT_W-1:0];
                CFG_FRAME_BYTES:    frame_bytes_reg <= cfg_data[FRAME_W-1:0];
                default:            ;
            endcase
        end
    end

    // window of bit j is the shift register after bits 0..j of the beat
    always_comb
    begin
        for (int i = 0; i < SYNC_WIDTH; i++)
        begin
            mask[i] = (sync_length_reg > LEN_W'(i));
        end
        wide = {shift_reg, s_tdata};
        for (int j = 0; j < NUM_LANES; j++)
        begin
            win[j] = wide[(NUM_LANES-1-j) +: SYNC_WIDTH] & mask;
        end
    end

    assign r3       = !v3_reg || merge_go;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign s_tready = r1;
    assign acc      = s_tvalid && r1;
    assign en.diff  = acc;
    assign en.part  = v1_reg && r2;
    assign en.match = v2_reg && r3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                shift_reg <= win[NUM_LANES-1];
            end
            if (en.diff)
            begin
                v1_reg <= 1'b1;
            end
            else if (en.part)
            begin
                v1_reg <= 1'b0;
            end
            if (en.part)
            begin
                v2_reg <= 1'b1;
            end
            else if (en.match)
            begin
                v2_reg <= 1'b0;
            end
            if (en.match)
            begin
                v3_reg <= 1'b1;
            end
            else if (merge_go)
            begin
                v3_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.diff)
        begin
            byte1_reg <= s_tdata;
        end
        if (en.part)
        begin
            byte2_reg <= byte1_reg;
        end
        if (en.match)
        begin
            byte3_reg <= byte2_reg;
        end
    end

    for (genvar j = 0; j < NUM_LANES; j++)
    begin : g_lane
        swd_lane #(
            .SYNC_WIDTH (SYNC_WIDTH)
        ) u_lane (
            .clk   (clk),
            .en    (en),
            .win   (win[j]),
            .word  (sync_word_reg),
            .mask  (mask),
            .limit (limit_reg),
            .match (lane_match[j])
        );
    end

    swd_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v3_reg),
        .lane_match  (lane_match),
        .bits        (byte3_reg),
        .frame_bytes (frame_bytes_reg),
        .go          (merge_go),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

/* dv/sync_word_bit_deframer_tb.sv */
// Self-checking testbench for sync_word_bit_deframer: streams byte beats, predicts frame bytes
// bit by bit in a scoreboard class and checks every output beat in order.
// Depends on rtl/swd_pkg.sv and rtl/sync_word_bit_deframer.sv.
`timescale 1ns / 1ps

module sync_word_bit_deframer_tb;
    import swd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_byte_t;

    class deframe_scoreboard;
        logic [CFG_W-1:0]   sync_word;
        logic [LEN_W-1:0]   sync_len;
        logic [LIMIT_W-1:0] limit;
        logic [FRAME_W-1:0] frame_len;
        logic [CFG_W-1:0]   shift;
        bit                 capturing;
        logic [BYTE_W-1:0]  pack;
        int unsigned        pack_bits;
        logic [FRAME_W-1:0] done_count;
        frame_byte_t        frame_byte_q[$];
        int                 errors;

        function new();
            sync_word  = '0;
            sync_len   = 7'd32;
            limit      = '0;
            frame_len  = 16'd256;
            shift      = '0;
            capturing  = 1'b0;
            pack       = '0;
            pack_bits  = 0;
            done_count = '0;
            errors     = 0;
        endfunction

        function logic [CFG_W-1:0] window_mask();
            if (sync_len >= 64)
                return '1;
            return (64'd1 << sync_len) - 64'd1;
        endfunction

        function void write_reg(cfg_reg_t addr, logic [CFG_W-1:0] value);
            case (addr)
                CFG_SYNC_WORD:      sync_word = value;
                CFG_SYNC_LENGTH:    sync_len  = value[LEN_W-1:0];
                CFG_MISMATCH_LIMIT: limit     = value[LIMIT_W-1:0];
                CFG_FRAME_BYTES:    frame_len = value[FRAME_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic [BYTE_W-1:0] b);
            logic [CFG_W-1:0] m;
            frame_byte_t      r;
            int unsigned      count;
            logic             bt;
            for (int i = BYTE_W - 1; i >= 0; i--) begin
                bt = b[i];
                m = window_mask();
                shift = ((shift << 1) | 64'(bt)) & m;
                if (capturing) begin
                    pack = {pack[BYTE_W-2:0], bt};
                    pack_bits++;
                    if (pack_bits == BYTE_W) begin
                        count = done_count + 1;
                        r.data = pack;
                        r.last = (count >= frame_len);
                        frame_byte_q = {frame_byte_q, r};
                        pack = '0;
                        pack_bits = 0;
                        if (r.last) begin
                            capturing = 1'b0;
                            done_count = '0;
                        end
                        else begin
                            done_count = count[FRAME_W-1:0];
                        end
                    end
                end
                else if ($countones((sync_word ^ shift) & m) <= limit) begin
                    capturing = 1'b1;
                    pack = '0;
                    pack_bits = 0;
                    done_count = '0;
                end
            end
        endfunction

        function void check_result(logic [BYTE_W-1:0] data, logic last);
            frame_byte_t want;
            if (frame_byte_q.size() == 0) begin
                $error("unexpected beat: out_byte actual %02h frame_last actual %0b", data, last);
                errors++;
                return;
            end
            want = frame_byte_q.pop_front();
            if (data !== want.data) begin
                $error("out_byte expected %02h actual %02h", want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $error("frame_last expected %0b actual %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return frame_byte_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [ADDR_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]   cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [BYTE_W-1:0]  m_tdata;
    logic               m_tlast;

    deframe_scoreboard sb = new();

    bit                 calm = 1'b0;
    bit                 hold_req = 1'b0;
    int                 beats_sent = 0;
    int                 cycle_count = 0;
    bit                 bit_q[$];

    logic [CFG_W-1:0]   cur_word;
    int                 cur_len;
    int                 cur_lim;
    int                 cur_frames;

    sync_word_bit_deframer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    // receiver: random stall bursts, a long hold on request, none when calm
    initial begin
        int stall_left = 0;
        int hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (calm || !rst_n) begin
                m_tready <= rst_n;
            end
            else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void append_bit(bit b);
        bit_q = {bit_q, b};
    endfunction

    task automatic send_beat(logic [BYTE_W-1:0] b);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        sb.note_input(b);
        beats_sent++;
    endtask

    task automatic flush_bits();
        logic [BYTE_W-1:0] b;
        while (bit_q.size() >= BYTE_W) begin
            for (int i = BYTE_W - 1; i >= 0; i--)
                b[i] = bit_q.pop_front();
            send_beat(b);
        end
    endtask

    // stop offering beats, wait for every expected byte, then let the pipeline empty
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_reg_t addr, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(posedge clk);
        sb.write_reg(addr, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // upper bits of the narrow registers carry noise; only the low bits count
    task automatic set_config(logic [CFG_W-1:0] word, int len, int lim, int frames);
        logic [CFG_W-1:0] noise;
        cur_word = word;
        cur_len = len;
        cur_lim = lim;
        cur_frames = frames;
        noise = {$urandom, $urandom};
        cfg_write(CFG_SYNC_WORD, word);
        cfg_write(CFG_SYNC_LENGTH, (noise & ~64'h7F) | 64'(len[LEN_W-1:0]));
        noise = {$urandom, $urandom};
        cfg_write(CFG_MISMATCH_LIMIT, (noise & ~64'h7F) | 64'(lim[LIMIT_W-1:0]));
        noise = {$urandom, $urandom};
        cfg_write(CFG_FRAME_BYTES, (noise & ~64'hFFFF) | 64'(frames[FRAME_W-1:0]));
    endtask

    // noise, a sync pattern with some bit errors (sometimes too many), then payload
    task automatic send_frames(int n);
        int               eff;
        int               flips;
        int               pos;
        int               payload;
        logic [CFG_W-1:0] pattern;
        eff = (cur_len > 64) ? 64 : cur_len;
        payload = (cur_frames == 0) ? 1 : ((cur_frames > 256) ? 256 : cur_frames);
        repeat (n) begin
            repeat ($urandom_range(0, 20)) append_bit(bit'($urandom_range(0, 1)));
            pattern = cur_word;
            if ($urandom_range(0, 7) == 0)
                flips = cur_lim + 1;
            else
                flips = $urandom_range(0, (cur_lim < eff) ? cur_lim : eff);
            if (eff > 0) begin
                repeat (flips) begin
                    pos = $urandom_range(0, eff - 1);
                    pattern[pos] = ~pattern[pos];
                end
            end
            for (int i = eff - 1; i >= 0; i--)
                append_bit(pattern[i]);
            repeat (payload * BYTE_W) append_bit(bit'($urandom_range(0, 1)));
            flush_bits();
        end
        while (bit_q.size() % BYTE_W != 0)
            append_bit(bit'($urandom_range(0, 1)));
        flush_bits();
    endtask

    initial begin
        int len;
        int lim;
        int frames;
        int eff;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: zero sync word matches at once, long frame
        send_beat(8'h00);
        send_beat(8'hFF);
        send_beat(8'hA5);
        send_beat(8'h5A);
        drain();

        // byte-aligned sync, one-byte frame, masked upper sync bits
        set_config({$urandom, 24'($urandom_range(0, 16777215)), 8'hB5}, 8, 0, 1);
        send_beat(8'hB5);
        send_beat(8'h3C);
        send_beat(8'h00);
        drain();

        // empty sync window and zero frame length
        set_config({$urandom, $urandom}, 0, 0, 0);
        send_beat(8'hFF);
        send_beat(8'h01);
        send_beat(8'h80);
        drain();

        // oversized sync length saturates to the full window
        set_config('1, 127, 0, 2);
        repeat (8) send_beat(8'hFF);
        send_beat(8'h12);
        send_beat(8'h34);
        drain();

        // limit far above the window: every bit is a match
        set_config({$urandom, $urandom}, 64, 127, 1);
        send_beat(8'h7E);
        send_beat(8'h81);
        drain();

        // frame length lowered mid-frame
        set_config(64'hB5, 8, 0, 5);
        send_beat(8'hB5);
        send_beat(8'h11);
        send_beat(8'h22);
        send_beat(8'h33);
        drain();
        cfg_write(CFG_FRAME_BYTES, 64'd2);
        cur_frames = 2;
        send_beat(8'h44);
        drain();

        // long output hold while the sender keeps pushing a long frame
        set_config({$urandom, $urandom}, 16, 16, 200);
        hold_req = 1'b1;
        send_frames(1);
        drain();

        while (beats_sent < 1000) begin
            if (beats_sent > 850)
                calm = 1'b1;
            case ($urandom_range(0, 9))
                0: case ($urandom_range(0, 4))
                       0: len = 0;
                       1: len = 1;
                       2: len = 64;
                       3: len = 100;
                       default: len = 127;
                   endcase
                default: len = $urandom_range(8, 64);
            endcase
            eff = (len > 64) ? 64 : len;
            case ($urandom_range(0, 7))
                0: case ($urandom_range(0, 3))
                       0: lim = eff;
                       1: lim = 64;
                       2: lim = 127;
                       default: lim = (eff > 0) ? eff - 1 : 0;
                   endcase
                1, 2: lim = 0;
                default: lim = $urandom_range(0, 3);
            endcase
            case ($urandom_range(0, 9))
                0: case ($urandom_range(0, 3))
                       0: frames = 0;
                       1: frames = 1;
                       2: frames = 16;
                       default: frames = 65535;
                   endcase
                default: frames = $urandom_range(1, 6);
            endcase
            drain();
            set_config({$urandom, $urandom}, len, lim, frames);
            send_frames((frames > 64) ? 1 : $urandom_range(2, 5));
            repeat ($urandom_range(0, 8)) send_beat(8'($urandom));
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
